// ----- rtl/ipdp_pkg.sv -----
// Package for the +IPD receive frame parser.
// Character codes, header step codes and the result and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipdp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] step_t;

  // Characters of the '+IPD,<id>,<len>:' header
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_I     = 8'h49;
  localparam byte_t CH_P     = 8'h50;
  localparam byte_t CH_D     = 8'h44;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_ZERO  = 8'h30;

  // Header step codes
  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_FIRST   = 4'd1;
  localparam step_t STEP_ID      = 4'd5;
  localparam step_t STEP_LEN     = 4'd7;
  localparam step_t STEP_PAYLOAD = 4'd9;

  // One parsed payload word plus its emit flag
  typedef struct packed {
    logic  emit;
    byte_t payload_byte;
    byte_t link_id;
    byte_t frame_length;
    byte_t byte_index;
    logic  last;
  } ipdp_res_t;

  // Parser status seen by the top level
  typedef struct packed {
    step_t step;
    byte_t count;
  } ipdp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ipdp_if.sv -----
// Valid/ready channel interfaces of the +IPD frame parser.
// Depends on ipdp_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel
interface ipdp_rx_if;
  logic            valid;
  logic            ready;
  ipdp_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Payload result channel
interface ipdp_res_if;
  logic            valid;
  logic            ready;
  ipdp_pkg::byte_t payload_byte;
  ipdp_pkg::byte_t link_id;
  ipdp_pkg::byte_t frame_length;
  ipdp_pkg::byte_t byte_index;
  logic            last;

  modport source (output valid, output payload_byte, output link_id, output frame_length,
                  output byte_index, output last, input ready);
  modport sink   (input valid, input payload_byte, input link_id, input frame_length,
                  input byte_index, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/ipdp_deframe.sv -----
// Header step machine and payload counter of the +IPD frame parser.
// Consumes one byte when fire_i is high; depends on ipdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipdp_deframe (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire ipdp_pkg::byte_t  byte_i,
  output ipdp_pkg::ipdp_res_t   res_o,
  output ipdp_pkg::ipdp_stat_t  stat_o
);
  import ipdp_pkg::*;

  step_t step_q, step_d;
  byte_t id_q, id_d;
  byte_t len_q, len_d;
  byte_t cnt_q, cnt_d;
  byte_t cnt_inc;

  assign cnt_inc = byte_t'(cnt_q + 8'd1);

  // Next state and result for the byte on offer
  always_comb begin
    step_d = step_q;
    id_d   = id_q;
    len_d  = len_q;
    cnt_d  = cnt_q;

    res_o.emit         = 1'b0;
    res_o.payload_byte = byte_i;
    res_o.link_id      = id_q;
    res_o.frame_length = len_q;
    res_o.byte_index   = cnt_q;
    res_o.last         = (cnt_inc == len_q);

    if (fire_i) begin
      if (byte_i == CH_PLUS) begin
        // a plus always restarts the header, even mid-payload
        step_d = STEP_FIRST;
      end else if (step_q >= STEP_FIRST && step_q < STEP_PAYLOAD) begin
        if (byte_i inside {CH_I, CH_P, CH_D, CH_COMMA}) begin
          step_d = step_t'(step_q + 4'd1);
        end else if (step_q == STEP_ID) begin
          id_d   = byte_t'(byte_i - CH_ZERO);
          step_d = step_t'(step_q + 4'd1);
        end else if (step_q == STEP_LEN) begin
          len_d  = byte_t'(byte_i - CH_ZERO);
          step_d = step_t'(step_q + 4'd1);
        end else if (byte_i == CH_COLON) begin
          step_d = step_t'(step_q + 4'd1);
          cnt_d  = '0;
        end
      end else if (step_q == STEP_PAYLOAD) begin
        res_o.emit = 1'b1;
        cnt_d      = cnt_inc;
        if (res_o.last) begin
          step_d = STEP_IDLE;
          cnt_d  = '0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      id_q   <= '0;
      len_q  <= '0;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      id_q   <= id_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
    end
  end

  assign stat_o = '{step: step_q, count: cnt_q};

endmodule

`default_nettype wire

// ----- rtl/ipd_frame_parser.sv -----
// Top level of the +IPD receive frame parser.
// Depends on ipdp_pkg, ipdp_if and ipdp_deframe.
`timescale 1ns / 1ps
`default_nettype none

// Takes received bytes on rx_i and deframes '+IPD,<id>,<len>:<payload>'
// notifications, streaming each payload byte on res_o with the link id,
// declared length, its index from 0 and a last flag. Header bytes produce
// no word. One byte is accepted every cycle, sustained, while res_o is
// ready. A payload word reaches res_o by way of the input register, which
// holds its byte, and then the result register, which takes the word when
// the byte advances. While a result waits untaken, one more byte is held
// in the input register and then the input stalls, header bytes included,
// until the result is taken.
// A '+' restarts the header at any point, dropping a partial frame without
// a last word. A length of 0 wraps the 8-bit count, ending after 256 bytes.
module ipd_frame_parser (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ipdp_rx_if.sink    rx_i,
  ipdp_res_if.source res_o
);
  import ipdp_pkg::*;

  logic       in_valid_q;
  byte_t      in_byte_q;
  logic       out_valid_q;
  logic       advance;
  ipdp_res_t  res;
  ipdp_stat_t stat;

  // Input register moves on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  ipdp_deframe u_deframe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res),
    .stat_o (stat)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.emit;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      res_o.payload_byte <= res.payload_byte;
      res_o.link_id      <= res.link_id;
      res_o.frame_length <= res.frame_length;
      res_o.byte_index   <= res.byte_index;
      res_o.last         <= res.last;
    end
  end

  assign res_o.valid = out_valid_q;

  // Checks
  a_last_matches_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_o.last |-> byte_t'(res_o.byte_index + 8'd1) == res_o.frame_length)
    else $error("last word index does not match frame length");

  a_plus_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_byte_q == CH_PLUS |=> stat.step == STEP_FIRST)
    else $error("plus did not restart the header");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.step <= STEP_PAYLOAD)
    else $error("header step beyond payload");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> in_valid_q && out_valid_q && !res_o.ready)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ----- bench/ipd_frame_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ipd_frame_parser: directed and random byte streams.
// The streams cover whole, broken and cut-short +IPD frames, and each payload word
// is checked against a local deframer. Depends on ipdp_pkg, ipdp_if and the RTL.

module ipd_frame_parser_tb;
  import ipdp_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;
  localparam int QUIET_TAIL  = 200;

  // Expected payload word, field for field as on res_o
  typedef struct packed {
    byte_t payload_byte;
    byte_t link_id;
    byte_t frame_length;
    byte_t byte_index;
    logic  last;
  } payload_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ipdp_rx_if  rx_if ();
  ipdp_res_if res_if ();

  ipd_frame_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Deframer state, mirrors the parser after reset
  step_t hdr_step  = STEP_IDLE;
  byte_t id_reg    = '0;
  byte_t len_reg   = '0;
  byte_t count_reg = '0;

  payload_word_t payload_q[$];
  byte_t         rx_bytes_q[$];
  int            frame_items = 0;
  int            mismatches  = 0;
  int            cycle_cnt   = 0;

  // Handshake bookkeeping between the edges
  bit rx_taken = 1'b0;
  bit rx_busy  = 1'b0;
  bit quiet    = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;

  // Advance the deframer by one received byte; payload bytes queue a word
  function automatic void deframe_byte(byte_t b);
    payload_word_t w;
    if (b == CH_PLUS) begin
      hdr_step = STEP_FIRST;
    end else if (hdr_step >= STEP_FIRST && hdr_step < STEP_PAYLOAD) begin
      if (b == CH_I || b == CH_P || b == CH_D || b == CH_COMMA) begin
        hdr_step = hdr_step + 4'd1;
      end else if (hdr_step == STEP_ID) begin
        id_reg   = b - CH_ZERO;
        hdr_step = hdr_step + 4'd1;
      end else if (hdr_step == STEP_LEN) begin
        len_reg  = b - CH_ZERO;
        hdr_step = hdr_step + 4'd1;
      end else if (b == CH_COLON) begin
        hdr_step  = hdr_step + 4'd1;
        count_reg = '0;
      end
    end else if (hdr_step == STEP_PAYLOAD) begin
      w.payload_byte = b;
      w.link_id      = id_reg;
      w.frame_length = len_reg;
      w.byte_index   = count_reg;
      count_reg      = count_reg + 8'd1;
      w.last         = (count_reg == len_reg);
      if (w.last) begin
        hdr_step  = STEP_IDLE;
        count_reg = '0;
      end
      payload_q.push_back(w);
    end
  endfunction

  function automatic void note_mismatch(string what, payload_word_t want, payload_word_t got);
    if (mismatches < REPORT_MAX) begin
      $write("%0t ns: %s: expected byte %h id %h len %h idx %h last %b, ",
             $time, what, want.payload_byte, want.link_id, want.frame_length,
             want.byte_index, want.last);
      $display("got byte %h id %h len %h idx %h last %b",
               got.payload_byte, got.link_id, got.frame_length, got.byte_index,
               got.last);
    end
    mismatches++;
  endfunction

  // Stimulus helpers
  function automatic void push_item(byte_t b);
    rx_bytes_q.push_back(b);
    frame_items++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(byte_t'(s[i]));
  endfunction

  function automatic void push_frame(byte_t id_b, byte_t len_b, byte_t end_b, int n);
    push_text("+IPD,");
    push_item(id_b);
    push_item(CH_COMMA);
    push_item(len_b);
    push_item(end_b);
    repeat (n) push_item(byte_t'($urandom_range(0, 255)));
  endfunction

  // Driver: new words and idle bursts go out on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      quiet = (rx_bytes_q.size() < QUIET_TAIL);
      // no idling at all in the tail of the run
      if (quiet) begin
        gap_left   = 0;
        stall_left = 0;
      end
      if (rx_taken) begin
        rx_taken = 1'b0;
        rx_busy  = 1'b0;
      end
      if (!rx_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 3);
          rx_if.valid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          rx_if.rx_byte <= rx_bytes_q.pop_front();
          rx_if.valid   <= 1'b1;
          rx_busy = 1'b1;
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
      // Result side back-pressure
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 3);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: accepted bytes feed the deframer, accepted words are checked
  always @(posedge clk_i) begin
    payload_word_t got;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte);
        rx_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        got.payload_byte = res_if.payload_byte;
        got.link_id      = res_if.link_id;
        got.frame_length = res_if.frame_length;
        got.byte_index   = res_if.byte_index;
        got.last         = res_if.last;
        if (payload_q.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else if (got !== payload_q[0]) begin
          note_mismatch("word mismatch", payload_q.pop_front(), got);
        end else begin
          void'(payload_q.pop_front());
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int    r;
    int    n;
    int    long_frames;
    byte_t id_b;
    byte_t len_b;
    byte_t end_b;

    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    long_frames   = 0;

    // Directed: idle bytes are dropped
    push_item(8'h41);
    push_item(8'h00);
    // id 0, length 1, single zero byte
    push_text("+IPD,0,1:");
    push_item(8'h00);
    // stray byte in the header is ignored, id wraps to 0xFF, '+' kills the payload
    push_text("+IPDx,/,2:");
    push_item(8'hFF);
    push_item(CH_PLUS);
    // header ends on ',' so the count carries on from the abandoned frame
    push_text("IPD,5,3,");
    push_item(8'h7E);
    push_item(8'h80);
    // ':' in the id slot is taken as the id
    push_text("+IPD,:,1:");
    push_item(8'h55);

    // Length zero wraps the count: 256 payload bytes
    push_frame(byte_t'(CH_ZERO + 8'd3), CH_ZERO, CH_COLON, 256);
    long_frames = 1;

    // Random: mostly well-formed frames, some broken headers, some noise
    while (frame_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        id_b  = ($urandom_range(0, 9) != 0) ? byte_t'(CH_ZERO + $urandom_range(0, 9))
                                            : byte_t'($urandom_range(0, 255));
        end_b = ($urandom_range(0, 9) != 0) ? CH_COLON : CH_COMMA;
        r = $urandom_range(0, 99);
        if (r < 2 && long_frames < 3) begin
          len_b = CH_ZERO;
          n     = 256;
          long_frames++;
        end else begin
          n     = (r < 8) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          len_b = byte_t'(CH_ZERO + n);
          // cut short now and then; the next '+' drops the partial frame
          if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
        end
        push_frame(id_b, len_b, end_b, n);
      end else if (r < 90) begin
        push_item(CH_PLUS);
        repeat (8) begin
          case ($urandom_range(0, 6))
            0: push_item(CH_I);
            1: push_item(CH_P);
            2: push_item(CH_D);
            3: push_item(CH_COMMA);
            4: push_item(CH_COLON);
            5: push_item(byte_t'(CH_ZERO + $urandom_range(0, 9)));
            default: push_item(byte_t'($urandom_range(0, 255)));
          endcase
        end
        repeat ($urandom_range(0, 4)) push_item(byte_t'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 5)) push_item(byte_t'($urandom_range(0, 255)));
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain the input, then the outstanding words, then let the pipe settle
    while (rx_bytes_q.size() != 0 || rx_busy) @(posedge clk_i);
    while (payload_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && payload_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
